>>> hw/rtl/tsfq_pkg.sv
// ----------------------------------------------------------------------------
// tsfq_pkg
// Shared types and constants for the turn signal flash qualifier.
// ----------------------------------------------------------------------------
package tsfq_pkg;

  localparam int DEB_W  = 7;   // debounce length and off-run counter
  localparam int EXT_W  = 7;   // hold extension
  localparam int STDY_W = 8;   // steady length and on-run counter
  localparam int HOLD_W = 8;   // hold counter
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int TDATA_W    = 8;

  localparam logic [DEB_W-1:0]  DEBOUNCE_MAX   = 7'd100;
  localparam logic [STDY_W-1:0] STEADY_MAX     = 8'd254;
  localparam logic [HOLD_W-1:0] HOLD_MAX       = 8'hFF;
  localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 7'd10;
  localparam logic [EXT_W-1:0]  EXTENSION_RESET = 7'd50;
  localparam logic [STDY_W-1:0] STEADY_RESET   = 8'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DEBOUNCE  = 2'd0,
    CFG_EXTENSION = 2'd1,
    CFG_STEADY    = 2'd2
  } cfg_addr_t;

  // Clamped settings as the channels use them
  typedef struct packed {
    logic [DEB_W-1:0]  deb;
    logic [EXT_W-1:0]  ext;
    logic [STDY_W-1:0] stdy;
  } chan_cfg_t;

  typedef struct packed {
    logic type_flag;
    logic active;
    logic flash;
  } chan_flags_t;

endpackage

>>> hw/rtl/tsfq_channel.sv
// ----------------------------------------------------------------------------
// tsfq_channel
// Run, off-run and hold counters plus the three flags of one lamp channel.
// ----------------------------------------------------------------------------
module tsfq_channel (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 lit,
  input  tsfq_pkg::chan_cfg_t  cfg,
  output tsfq_pkg::chan_flags_t flags
);
  import tsfq_pkg::*;

  logic [STDY_W-1:0] on_run_r,  on_run_nxt;
  logic [DEB_W-1:0]  off_run_r, off_run_nxt;
  logic [HOLD_W-1:0] hold_r,    hold_nxt;
  logic              flash_r,   flash_nxt;
  logic              active_r,  active_nxt;
  logic              type_r,    type_nxt;

  logic [STDY_W-1:0] on_inc;
  logic [DEB_W:0]    off_inc;
  logic [HOLD_W:0]   hold_sum;
  logic [HOLD_W-1:0] hold_cap;

  always_comb begin
    on_inc   = on_run_r + 1'b1;
    off_inc  = {1'b0, off_run_r} + 1'b1;
    hold_sum = {1'b0, hold_r} + {{(HOLD_W+1-EXT_W){1'b0}}, cfg.ext};
    hold_cap = HOLD_MAX - {{(HOLD_W-EXT_W){1'b0}}, cfg.ext};

    on_run_nxt  = on_run_r;
    off_run_nxt = off_run_r;
    hold_nxt    = hold_r;
    flash_nxt   = flash_r;
    active_nxt  = active_r;
    type_nxt    = type_r;

    if (lit) begin
      off_run_nxt = '0;
      on_run_nxt  = on_inc;
      if (on_run_r > {1'b0, cfg.deb}) begin
        if (on_inc > cfg.stdy) begin
          on_run_nxt = cfg.stdy + 1'b1;
          type_nxt   = 1'b0;
        end
        if (hold_r < hold_cap) begin
          hold_nxt = hold_r + 1'b1;
        end
        flash_nxt  = 1'b1;
        active_nxt = 1'b1;
      end
    end else begin
      on_run_nxt  = '0;
      off_run_nxt = off_inc[DEB_W-1:0];
      if (off_run_r == cfg.deb) begin
        // debounce point: extend hold, saturating
        hold_nxt  = hold_sum[HOLD_W] ? HOLD_MAX : hold_sum[HOLD_W-1:0];
        flash_nxt = 1'b0;
      end else if (off_inc > {1'b0, cfg.deb}) begin
        off_run_nxt = cfg.deb + 1'b1;
        type_nxt    = 1'b1;
        if (hold_r == '0) begin
          active_nxt = 1'b0;
        end else begin
          hold_nxt = hold_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_run_r  <= '0;
      off_run_r <= '0;
      hold_r    <= '0;
      flash_r   <= 1'b0;
      active_r  <= 1'b0;
      type_r    <= 1'b0;
    end else if (en) begin
      on_run_r  <= on_run_nxt;
      off_run_r <= off_run_nxt;
      hold_r    <= hold_nxt;
      flash_r   <= flash_nxt;
      active_r  <= active_nxt;
      type_r    <= type_nxt;
    end
  end

  assign flags.flash     = flash_r;
  assign flags.active    = active_r;
  assign flags.type_flag = type_r;

endmodule

>>> hw/rtl/turn_signal_flash_qualifier_unit.sv
// ----------------------------------------------------------------------------
// turn_signal_flash_qualifier_unit
// Qualifies raw left/right turn lamp levels into flash, active and type flags.
// ----------------------------------------------------------------------------
//  channel | direction | content
//  in_     | slave     | one tick: left_lamp, right_lamp
//  out_    | master    | one result per tick: six flags
//  cfg_    | write     | debounce_ticks, hold_extension, steady_ticks
//
//  Flow: a beat is taken every cycle unless the output stalls; it is held in the
//  input register and moves into the channel registers once the result slot is
//  free, and its result is then on out_.
//  The input register doubles as a skid stage, so a new beat is accepted
//  while a finished result still waits on out_tready.
//  The channel flag registers are the result register: they only advance when
//  the output is empty or being taken, so they hold steady under a stall.
//  Reset (rst_n low, synchronous) clears all counters and flags, drops both
//  valid bits and loads the register defaults 10 / 50 / 100.
// ----------------------------------------------------------------------------
module turn_signal_flash_qualifier_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: [0] left_lamp, [1] right_lamp, [7:2] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tsfq_pkg::TDATA_W-1:0]      in_tdata,
  // out_tdata: [0] left_flash, [1] left_active, [2] left_type,
  //            [3] right_flash, [4] right_active, [5] right_type, [7:6] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tsfq_pkg::TDATA_W-1:0]      out_tdata,
  input  logic                              cfg_we,
  input  logic [tsfq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [tsfq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tsfq_pkg::*;

  // Configuration registers, raw as written
  logic [DEB_W-1:0]  deb_r;
  logic [EXT_W-1:0]  ext_r;
  logic [STDY_W-1:0] stdy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r  <= DEBOUNCE_RESET;
      ext_r  <= EXTENSION_RESET;
      stdy_r <= STEADY_RESET;
    end else if (cfg_we) begin
      case (cfg_addr_t'(cfg_addr))
        CFG_DEBOUNCE:  deb_r  <= cfg_wdata[DEB_W-1:0];
        CFG_EXTENSION: ext_r  <= cfg_wdata[EXT_W-1:0];
        CFG_STEADY:    stdy_r <= cfg_wdata[STDY_W-1:0];
        default: ;   // drop writes to unmapped indexes
      endcase
    end
  end

  // Clamp so the run counters never leave their widths
  chan_cfg_t cfg;
  always_comb begin
    cfg.deb  = (deb_r > DEBOUNCE_MAX) ? DEBOUNCE_MAX : deb_r;
    cfg.ext  = ext_r;
    cfg.stdy = (stdy_r > STEADY_MAX) ? STEADY_MAX : stdy_r;
  end

  // Input register / skid stage
  logic       s0_valid_r;
  logic [1:0] s0_lamp_r;
  logic       out_valid_r;
  logic       advance;

  // Move the held tick into the channels when the result slot is free
  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_lamp_r <= in_tdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  chan_flags_t left_flags, right_flags;

  tsfq_channel u_left (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .lit   (s0_lamp_r[0]),
    .cfg   (cfg),
    .flags (left_flags)
  );

  tsfq_channel u_right (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .lit   (s0_lamp_r[1]),
    .cfg   (cfg),
    .flags (right_flags)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       right_flags.type_flag, right_flags.active, right_flags.flash,
                       left_flags.type_flag,  left_flags.active,  left_flags.flash};

  // Every tick moved into the channels shows up as a result next cycle
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("tick advanced without a result");

  // A held tick stays put while the result slot is blocked
  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_valid_r && !advance) |=> (s0_valid_r && $stable(s0_lamp_r)))
    else $error("skid stage lost its tick");

  // Channel state only moves when a tick advances
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(out_tdata))
    else $error("flags changed without a tick");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the turn signal flash qualifier unit: a queue-fed
// driver streams lamp ticks, a monitor predicts the six flags of every tick
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import tsfq_pkg::*;

  // One result beat, lowest bit first: left_flash .. right_type
  typedef struct packed {
    logic right_type;
    logic right_active;
    logic right_flash;
    logic left_type;
    logic left_active;
    logic left_flash;
  } lamp_flags_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DEBOUNCE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Ticks waiting to be sent, {right_lamp, left_lamp}
  logic [1:0]  tick_queue[$];
  // Predicted flags, oldest first
  lamp_flags_t flags_due[$];

  logic in_acc = 1'b0;    // input beat taken at the last rising edge
  bit   calm = 1'b0;      // no idling on either side while set
  int   mismatches = 0;
  int   results_seen = 0;

  // Shadow of the register file and of both lamp channels (0 left, 1 right)
  logic [DEB_W-1:0]  deb_reg;
  logic [EXT_W-1:0]  ext_reg;
  logic [STDY_W-1:0] stdy_reg;
  logic [STDY_W-1:0] on_run_m[2];
  logic [DEB_W-1:0]  off_run_m[2];
  logic [HOLD_W-1:0] hold_m[2];
  bit                flash_m[2];
  bit                active_m[2];
  bit                kind_m[2];

  turn_signal_flash_qualifier_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Advance one lamp channel by one tick. Debounce above its range acts as
  // its maximum, and a steady length of 255 acts as 254, so the run counters
  // never leave their widths.
  function automatic void lamp_tick(input int ch, input bit lit);
    int d, s, e, prev, nxt, h, hmax;
    d    = (deb_reg > DEBOUNCE_MAX) ? DEBOUNCE_MAX : deb_reg;
    s    = (stdy_reg > STEADY_MAX) ? STEADY_MAX : stdy_reg;
    e    = ext_reg;
    h    = hold_m[ch];
    hmax = HOLD_MAX;
    if (lit) begin
      prev = on_run_m[ch];
      nxt  = (prev + 1) & 8'hFF;
      off_run_m[ch] = '0;
      // Lamp lit past debounce: qualify it, grow hold up to its cap
      if (prev > d) begin
        if (nxt > s) begin
          nxt = s + 1;
          kind_m[ch] = 1'b0;
        end
        if (h < hmax - e)
          h = h + 1;
        flash_m[ch]  = 1'b1;
        active_m[ch] = 1'b1;
      end
      on_run_m[ch] = STDY_W'(nxt);
    end else begin
      prev = off_run_m[ch];
      nxt  = (prev + 1) & 7'h7F;
      on_run_m[ch] = '0;
      if (prev == d) begin
        // Lamp just accepted as dark: extend the hold, saturating at the top
        h = (h + e > hmax) ? hmax : h + e;
        flash_m[ch] = 1'b0;
      end else if (prev + 1 > d) begin
        // Past the dark point: run the hold down, drop active at zero
        nxt = d + 1;
        kind_m[ch] = 1'b1;
        if (h == 0)
          active_m[ch] = 1'b0;
        else
          h = h - 1;
      end
      off_run_m[ch] = DEB_W'(nxt & 7'h7F);
    end
    hold_m[ch] = HOLD_W'(h);
  endfunction

  task automatic report_mismatch(input string field, input logic got, input logic want);
    if (mismatches < 40)
      $display("result %0d: %s is %b, expected %b", results_seen, field, got, want);
    mismatches++;
  endtask

  // Monitor: track register writes, check result beats, predict input beats.
  // Check before predict so a beat leaving and one entering on the same edge
  // never see each other.
  always @(posedge clk) begin
    lamp_flags_t got, want;
    if (!rst_n) begin
      in_acc   <= 1'b0;
      deb_reg  = DEBOUNCE_RESET;
      ext_reg  = EXTENSION_RESET;
      stdy_reg = STEADY_RESET;
      for (int ch = 0; ch < 2; ch++) begin
        on_run_m[ch]  = '0;
        off_run_m[ch] = '0;
        hold_m[ch]    = '0;
        flash_m[ch]   = 1'b0;
        active_m[ch]  = 1'b0;
        kind_m[ch]    = 1'b0;
      end
    end else begin
      in_acc <= in_tvalid && in_tready;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DEBOUNCE:  deb_reg  = cfg_wdata[DEB_W-1:0];
          CFG_EXTENSION: ext_reg  = cfg_wdata[EXT_W-1:0];
          CFG_STEADY:    stdy_reg = cfg_wdata[STDY_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[5:0];
        if (flags_due.size() == 0) begin
          report_mismatch("unexpected beat", 1'b1, 1'b0);
        end else begin
          want = flags_due.pop_front();
          if (got.left_flash !== want.left_flash)
            report_mismatch("left_flash", got.left_flash, want.left_flash);
          if (got.left_active !== want.left_active)
            report_mismatch("left_active", got.left_active, want.left_active);
          if (got.left_type !== want.left_type)
            report_mismatch("left_type", got.left_type, want.left_type);
          if (got.right_flash !== want.right_flash)
            report_mismatch("right_flash", got.right_flash, want.right_flash);
          if (got.right_active !== want.right_active)
            report_mismatch("right_active", got.right_active, want.right_active);
          if (got.right_type !== want.right_type)
            report_mismatch("right_type", got.right_type, want.right_type);
          if (out_tdata[7:6] !== 2'b00)
            report_mismatch("padding", 1'b1, 1'b0);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        lamp_tick(0, in_tdata[0]);
        lamp_tick(1, in_tdata[1]);
        want.left_flash   = flash_m[0];
        want.left_active  = active_m[0];
        want.left_type    = kind_m[0];
        want.right_flash  = flash_m[1];
        want.right_active = active_m[1];
        want.right_type   = kind_m[1];
        flags_due.push_back(want);
      end
    end
  end

  // Driver: hold a beat until taken, then advance from the queue or idle.
  // The output side stalls at random with the same odds.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      out_tready <= 1'b0;
    end else begin
      if (!in_tvalid || in_acc) begin
        if (tick_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 22)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, tick_queue.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  // Wait until every tick is sent and every result is back, then let the
  // pipeline settle.
  task automatic drain();
    while (tick_queue.size() != 0 || in_tvalid || flags_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles; block must be idle
  task automatic write_regs(input int deb, input int ext, input int stdy);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_DEBOUNCE;
    cfg_wdata <= CFG_DATA_W'(deb);
    @(negedge clk);
    cfg_addr  <= CFG_EXTENSION;
    cfg_wdata <= CFG_DATA_W'(ext);
    @(negedge clk);
    cfg_addr  <= CFG_STEADY;
    cfg_wdata <= CFG_DATA_W'(stdy);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_run(input bit left, input bit right, input int n);
    repeat (n) tick_queue.push_back({right, left});
  endtask

  // Length of one lamp run: mostly near the debounce point so both edges
  // get qualified, some glitches, some long runs to drain the hold count
  function automatic int pick_run(input int d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return $urandom_range(1, 2);
    else if (r < 88)
      return $urandom_range((d > 0) ? d : 1, d + 6);
    else
      return $urandom_range(d + 1, d + 260);
  endfunction

  // Flashing lamps with random on/off lengths, each lamp on its own rhythm
  task automatic run_phase(input int deb, input int ext, input int stdy,
                           input int n, input bit quiet);
    bit lvl[2];
    int left_n[2];
    int d;
    write_regs(deb, ext, stdy);
    calm = quiet;
    d = (deb > DEBOUNCE_MAX) ? DEBOUNCE_MAX : deb;
    for (int ch = 0; ch < 2; ch++) begin
      lvl[ch]    = 1'($urandom_range(0, 1));
      left_n[ch] = 0;
    end
    for (int i = 0; i < n; i++) begin
      for (int ch = 0; ch < 2; ch++) begin
        if (left_n[ch] == 0) begin
          lvl[ch]    = !lvl[ch];
          left_n[ch] = pick_run(d);
        end
        left_n[ch]--;
      end
      tick_queue.push_back({lvl[1], lvl[0]});
    end
    drain();
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: left lit long enough to qualify, then right, each
    // going dark as the other lights
    push_run(1'b1, 1'b0, 12);
    push_run(1'b0, 1'b1, 12);
    drain();

    // Debounce of zero: the first dark tick extends the hold at once
    write_regs(0, 127, 2);
    push_run(1'b1, 1'b1, 3);
    push_run(1'b0, 1'b0, 2);
    push_run(1'b1, 1'b0, 1);
    push_run(1'b0, 1'b1, 1);
    drain();

    run_phase(10, 50, 100, 60, 1'b0);
    run_phase(1, 0, 2, 30, 1'b0);
    run_phase(100, 127, 254, 100, 1'b0);
    // Debounce above range and steady of 255
    run_phase(127, 5, 255, 30, 1'b0);
    run_phase(0, 20, 30, 30, 1'b0);
    // Steady not above debounce; keep both sides busy on every cycle
    run_phase(20, 10, 15, 60, 1'b1);

    // Hold overflow: grow the hold with no extension, then raise the
    // extension and go dark so the sum passes the top
    write_regs(2, 0, 254);
    push_run(1'b1, 1'b1, 135);
    drain();
    write_regs(2, 127, 254);
    push_run(1'b0, 1'b0, 20);
    drain();

    run_phase(5, 30, 12, 40, 1'b0);

    if (flags_due.size() != 0)
      report_mismatch("results missing", 1'b1, 1'b0);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
